>>> hdl/page_residency_manager_assert.svh
// assertion macros used by the checker file prm_checker.sv
`ifndef PAGE_RESIDENCY_MANAGER_ASSERT_SVH
`define PAGE_RESIDENCY_MANAGER_ASSERT_SVH

// checked only outside reset
`define PRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PRM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/prm_pkg.sv
`default_nettype none

package prm_pkg;

  localparam int PAGE_LOG2  = 12;
  localparam int NUM_PAGES  = 4096;
  localparam int MAX_LENGTH = 65536;
  localparam int SPAN_LIMIT = 17;

  // field widths
  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 24;
  localparam int LEN_W   = 17;
  localparam int BYTES_W = 25;
  localparam int CNT_W   = 13;
  localparam int PAGE_W  = 12;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(4096);

  // shared adder: operand width and result width with carry
  localparam int OPW    = BYTES_W;
  localparam int ALU_W  = OPW + 1;
  localparam int FIRST_W = ADDR_W - PAGE_LOG2;
  localparam int ENDP_W  = OPW - PAGE_LOG2;
  localparam int NEED_W  = ALU_W - PAGE_LOG2;

  localparam int SPAN_W     = $clog2(SPAN_LIMIT + 1);
  localparam int LIST_IDX_W = $clog2(SPAN_LIMIT);
  localparam int RAM_AW     = $clog2(NUM_PAGES);

  // slave tdata layout
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_LEN_LSB   = IN_ADDR_LSB + ADDR_W;
  localparam int IN_BYTES_LSB = IN_LEN_LSB + LEN_W;
  localparam int IN_CNT_LSB   = IN_BYTES_LSB + BYTES_W;
  localparam int IN_PIDX_LSB  = IN_CNT_LSB + CNT_W;
  localparam int IN_RAW_W     = IN_PIDX_LSB + PAGE_W;
  localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;

  // master tdata layout
  localparam int OUT_PAGE_LSB = 0;
  localparam int OUT_STAT_LSB = OUT_PAGE_LSB + PAGE_W;
  localparam int OUT_FREE_LSB = OUT_STAT_LSB + STAT_W;
  localparam int OUT_REM_LSB  = OUT_FREE_LSB + CNT_W;
  localparam int OUT_RAW_W    = OUT_REM_LSB + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN        = 3'd0,
    CMD_PLACE       = 3'd1,
    CMD_ALLOC_BYTES = 3'd2,
    CMD_ALLOC_CNT   = 3'd3,
    CMD_FREE_CNT    = 3'd4,
    CMD_VALIDATE    = 3'd5,
    CMD_INVALIDATE  = 3'd6,
    CMD_RESET_CNT   = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_ERROR   = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RNG_SUM,
    ST_RNG_END,
    ST_RNG_SPAN,
    ST_WALK,
    ST_POST_REM,
    ST_POST_FREE,
    ST_BYTES_NEED,
    ST_SUB_FREE,
    ST_ADD_FREE,
    ST_CHK_TOTAL,
    ST_PAGE_RD,
    ST_PAGE_WR,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

>>> hdl/prm_ram.sv
`default_nettype none

module prm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/page_residency_manager.sv
// Page residency manager.
// Commands arrive as beats on the s_t* channel (command in s_tuser, operands in
// s_tdata); results leave as beats on the m_t* channel. Every command returns
// zero or more listed pages (m_tuser high) in ascending order, then one final
// beat with m_tlast high carrying the status. Counts on every beat are those
// after the whole command. total_pages is written on the cfg channel, which
// is always ready; reset counters loads it and free count is bounded by it.
// One command is handled at a time; s_tready is high only while idle.
// Scan and place sum, end and span the range, then walk its pages (up to 17,
// one per cycle through the valid-bit memory); place then updates remain and
// free counts. Alloc bytes rounds up, then subtracts; alloc count subtracts;
// free count adds, then checks the total; validate/invalidate read, then
// write the page bit; reset counters loads both counts. Result beats follow.
// All count and range arithmetic runs through one shared 25-bit adder, one
// step per cycle. After reset the valid-bit memory is swept clear (s_tready
// low). A stalled receiver holds the output register and the sequencer waits.
`default_nettype none

module page_residency_manager (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // address, length, byte_size, page_count, page_idx, zero pad
  input  wire logic [prm_pkg::IN_TDATA_W-1:0]  s_tdata,
  // command
  input  wire logic [prm_pkg::CMD_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // page_number, status, free_count, remain_count
  output logic      [prm_pkg::OUT_TDATA_W-1:0] m_tdata,
  // page_listed
  output logic                                m_tuser,
  output logic                                m_tlast,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [prm_pkg::CNT_W-1:0]       cfg_wdata_i
);

  import prm_pkg::*;

  state_e state_q, state_d;
  cmd_e   cmd_q;
  stat_e  stat_q, stat_d;

  logic [ADDR_W-1:0]  addr_q;
  logic [LEN_W-1:0]   len_q;
  logic [BYTES_W-1:0] bsize_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PAGE_W-1:0]  pidx_q;

  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] remain_q, remain_d;

  logic [ALU_W-1:0] alu_q, alu_d;
  logic [OPW-1:0]   alu_a, alu_b;
  logic             alu_cin;
  logic [ALU_W-1:0] alu_res;
  logic             alu_carry;

  logic [PAGE_W-1:0] rd_page_q, rd_page_d;
  logic [SPAN_W-1:0] rd_left_q, rd_left_d;
  logic              chk_vld_q, chk_vld_d;
  logic [PAGE_W-1:0] chk_page_q, chk_page_d;
  logic [SPAN_W-1:0] n_q, n_d;
  logic [SPAN_W-1:0] e_q, e_d;
  logic [PAGE_W-1:0] list_q [SPAN_LIMIT];
  logic              list_we;
  logic [PAGE_W-1:0] clr_q, clr_d;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic              ram_wdata, ram_rdata;

  logic              m_tvalid_q;
  logic              out_ld, out_ld_list;
  logic [PAGE_W-1:0] out_page_q;
  logic              out_listed_q;
  stat_e             out_stat_q;
  logic              out_last_q;
  logic [CNT_W-1:0]  out_free_q, out_remain_q;

  logic               in_acc;
  logic [FIRST_W-1:0] first_page;
  logic [ENDP_W-1:0]  last_page;
  logic [NEED_W-1:0]  need;
  logic [OPW-1:0]     span;
  logic               place_ok;

  assign in_acc     = s_tvalid && s_tready;
  assign s_tready   = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign first_page = addr_q[ADDR_W-1:PAGE_LOG2];
  assign last_page  = alu_q[OPW-1:PAGE_LOG2];
  assign need       = alu_q[ALU_W-1:PAGE_LOG2];
  assign span       = alu_res[OPW-1:0];
  assign place_ok   = (cmd_q == CMD_SCAN) || (remain_q > CNT_W'(n_q));

  // the one shared adder
  assign alu_res   = {1'b0, alu_a} + {1'b0, alu_b} + ALU_W'(alu_cin);
  assign alu_carry = alu_res[ALU_W-1];

  prm_ram #(
    .WIDTH (1),
    .DEPTH (NUM_PAGES)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    stat_d     = stat_q;
    free_d     = free_q;
    remain_d   = remain_q;
    alu_d      = alu_q;
    alu_a      = '0;
    alu_b      = '0;
    alu_cin    = 1'b0;
    rd_page_d  = rd_page_q;
    rd_left_d  = rd_left_q;
    chk_vld_d  = chk_vld_q;
    chk_page_d = chk_page_q;
    n_d        = n_q;
    e_d        = e_q;
    clr_d      = clr_q;
    list_we    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = chk_page_q;
    ram_wdata  = 1'b1;
    ram_raddr  = rd_page_q;
    out_ld      = 1'b0;
    out_ld_list = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        clr_d     = clr_q + PAGE_W'(1);
        if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          stat_d = STAT_OK;
          n_d    = '0;
          e_d    = '0;
          unique case (cmd_e'(s_tuser)) inside
            CMD_SCAN, CMD_PLACE:          state_d = ST_RNG_SUM;
            CMD_ALLOC_BYTES:              state_d = ST_BYTES_NEED;
            CMD_ALLOC_CNT:                state_d = ST_SUB_FREE;
            CMD_FREE_CNT:                 state_d = ST_ADD_FREE;
            CMD_VALIDATE, CMD_INVALIDATE: state_d = ST_PAGE_RD;
            CMD_RESET_CNT: begin
              free_d   = total_q;
              remain_d = total_q;
              state_d  = ST_EMIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RNG_SUM: begin
        alu_a = OPW'(addr_q);
        alu_b = OPW'(len_q);
        alu_d = alu_res;
        if (len_q == '0 || 32'(len_q) > MAX_LENGTH) begin
          stat_d  = STAT_ERROR;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_RNG_END;
        end
      end
      ST_RNG_END: begin
        // end address = start + length - 1
        alu_a   = alu_q[OPW-1:0];
        alu_b   = '1;
        alu_d   = {1'b0, alu_res[OPW-1:0]};
        state_d = ST_RNG_SPAN;
      end
      ST_RNG_SPAN: begin
        alu_a   = OPW'(last_page);
        alu_b   = ~OPW'(first_page);
        alu_cin = 1'b1;
        if (32'(last_page) >= NUM_PAGES || span >= OPW'(SPAN_LIMIT)) begin
          stat_d  = STAT_ERROR;
          state_d = ST_EMIT;
        end else begin
          rd_page_d = PAGE_W'(first_page);
          rd_left_d = span[SPAN_W-1:0] + SPAN_W'(1);
          chk_vld_d = 1'b0;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        // read one page ahead of the one being decided
        if (rd_left_q != '0) begin
          chk_vld_d  = 1'b1;
          chk_page_d = rd_page_q;
          rd_page_d  = rd_page_q + PAGE_W'(1);
          rd_left_d  = rd_left_q - SPAN_W'(1);
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q && !ram_rdata && place_ok) begin
          list_we = 1'b1;
          n_d     = n_q + SPAN_W'(1);
          ram_we  = (cmd_q == CMD_PLACE);
        end
        if (rd_left_q == '0 && !chk_vld_q) begin
          state_d = (cmd_q == CMD_PLACE) ? ST_POST_REM : ST_EMIT;
        end
      end
      ST_POST_REM: begin
        alu_a    = OPW'(remain_q);
        alu_b    = ~OPW'(n_q);
        alu_cin  = 1'b1;
        remain_d = alu_res[CNT_W-1:0];
        state_d  = ST_POST_FREE;
      end
      ST_POST_FREE: begin
        // free count saturates at zero
        alu_a   = OPW'(free_q);
        alu_b   = ~OPW'(n_q);
        alu_cin = 1'b1;
        free_d  = alu_carry ? alu_res[CNT_W-1:0] : '0;
        state_d = ST_EMIT;
      end
      ST_BYTES_NEED: begin
        // round up to whole pages
        alu_a = bsize_q;
        alu_b = OPW'((1 << PAGE_LOG2) - 1);
        alu_d = alu_res;
        if (bsize_q == '0) begin
          stat_d  = STAT_REFUSED;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SUB_FREE;
        end
      end
      ST_SUB_FREE: begin
        alu_a   = OPW'(free_q);
        alu_b   = (cmd_q == CMD_ALLOC_BYTES) ? ~OPW'(need) : ~OPW'(cnt_q);
        alu_cin = 1'b1;
        if (alu_carry) begin
          free_d = alu_res[CNT_W-1:0];
        end else begin
          stat_d = (cmd_q == CMD_ALLOC_BYTES) ? STAT_REFUSED : STAT_ERROR;
        end
        state_d = ST_EMIT;
      end
      ST_ADD_FREE: begin
        alu_a   = OPW'(free_q);
        alu_b   = OPW'(cnt_q);
        alu_d   = alu_res;
        state_d = ST_CHK_TOTAL;
      end
      ST_CHK_TOTAL: begin
        // sum stays in alu_q; total - sum must not borrow
        alu_a   = OPW'(total_q);
        alu_b   = ~alu_q[OPW-1:0];
        alu_cin = 1'b1;
        if (alu_carry) begin
          free_d = alu_q[CNT_W-1:0];
        end else begin
          stat_d = STAT_ERROR;
        end
        state_d = ST_EMIT;
      end
      ST_PAGE_RD: begin
        ram_raddr = pidx_q;
        state_d   = ST_PAGE_WR;
      end
      ST_PAGE_WR: begin
        ram_waddr = pidx_q;
        ram_wdata = (cmd_q == CMD_VALIDATE);
        if (32'(pidx_q) >= NUM_PAGES) begin
          stat_d = STAT_ERROR;
        end else if ((cmd_q == CMD_VALIDATE) == ram_rdata) begin
          stat_d = STAT_ERROR;
        end else begin
          ram_we = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid_q || m_tready) begin
          out_ld = 1'b1;
          if (e_q < n_q) begin
            out_ld_list = 1'b1;
            e_d         = e_q + SPAN_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      stat_q     <= STAT_OK;
      total_q    <= TOTAL_RESET;
      free_q     <= TOTAL_RESET;
      remain_q   <= TOTAL_RESET;
      rd_left_q  <= '0;
      chk_vld_q  <= 1'b0;
      n_q        <= '0;
      e_q        <= '0;
      clr_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      stat_q    <= stat_d;
      free_q    <= free_d;
      remain_q  <= remain_d;
      rd_left_q <= rd_left_d;
      chk_vld_q <= chk_vld_d;
      n_q       <= n_d;
      e_q       <= e_d;
      clr_q     <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_wdata_i;
      end
      if (out_ld) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    alu_q      <= alu_d;
    rd_page_q  <= rd_page_d;
    chk_page_q <= chk_page_d;
    if (in_acc) begin
      cmd_q   <= cmd_e'(s_tuser);
      addr_q  <= s_tdata[IN_ADDR_LSB +: ADDR_W];
      len_q   <= s_tdata[IN_LEN_LSB +: LEN_W];
      bsize_q <= s_tdata[IN_BYTES_LSB +: BYTES_W];
      cnt_q   <= s_tdata[IN_CNT_LSB +: CNT_W];
      pidx_q  <= s_tdata[IN_PIDX_LSB +: PAGE_W];
    end
    if (list_we) begin
      list_q[n_q[LIST_IDX_W-1:0]] <= chk_page_q;
    end
    if (out_ld) begin
      out_page_q   <= out_ld_list ? list_q[e_q[LIST_IDX_W-1:0]] : '0;
      out_listed_q <= out_ld_list;
      out_stat_q   <= out_ld_list ? STAT_OK : stat_q;
      out_last_q   <= !out_ld_list;
      out_free_q   <= free_q;
      out_remain_q <= remain_q;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = OUT_TDATA_W'({out_remain_q, out_free_q, out_stat_q, out_page_q});
  assign m_tuser  = out_listed_q;
  assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> hdl/prm_checker.sv
`default_nettype none

`include "page_residency_manager_assert.svh"

module prm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [prm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tuser,
  input wire logic                           m_tlast
);

  import prm_pkg::*;

  // a stalled beat keeps its payload
  `PRM_ASSERT(a_out_hold,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser),
    "output beat changed while stalled")

  // listed pages are never final and carry ok status
  `PRM_ASSERT(a_listed_beat,
    m_tvalid && m_tuser |-> !m_tlast && m_tdata[OUT_STAT_LSB +: STAT_W] == STAT_OK,
    "listed beat with last or nonzero status")

  // only the final beat of a command may still wait when a new command is taken
  `PRM_ASSERT(a_one_cmd,
    s_tready && m_tvalid |-> m_tlast && !m_tuser
      && m_tdata[OUT_PAGE_LSB +: PAGE_W] == '0,
    "new command taken before listed beats drained")

  // a taken command drops s_tready in the following cycle
  `PRM_ASSERT(a_busy_after_cmd, s_tvalid && s_tready |=> !s_tready,
    "ready stayed high after a command beat")

  // in reset nothing is offered or taken
  `PRM_ASSERT_RST(a_reset_quiet, !rst_ni |-> !m_tvalid && !s_tready,
    "handshake active during reset")

endmodule

bind page_residency_manager prm_checker u_prm_checker (.*);

`default_nettype wire

>>> sim/prm_stream_checker.sv
`timescale 1ns / 1ps

module prm_stream_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [prm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic [prm_pkg::CMD_W-1:0]       s_tuser,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic [prm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                            m_tuser,
  input  wire logic                            m_tlast,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_o,
  input  wire logic [prm_pkg::CNT_W-1:0]       cfg_wdata_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);

  import prm_pkg::*;

  typedef struct {
    logic [PAGE_W-1:0] page_number;
    logic              page_listed;
    stat_e             status;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  remain_count;
    logic              last;
  } result_beat_t;

  bit               resident [NUM_PAGES];
  logic [CNT_W-1:0] free_left;
  logic [CNT_W-1:0] place_left;
  logic [CNT_W-1:0] total_pages;
  result_beat_t     expected_beats[$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic push_beat(input logic [PAGE_W-1:0] page, input logic listed,
                           input stat_e st, input logic last);
    result_beat_t b;
    b.page_number  = page;
    b.page_listed  = listed;
    b.status       = st;
    b.free_count   = free_left;
    b.remain_count = place_left;
    b.last         = last;
    expected_beats.insert(expected_beats.size(), b);
  endtask

  // updates residency and counters for one command and queues its beats
  task automatic predict_command(input cmd_e cmd, input logic [IN_TDATA_W-1:0] data);
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [BYTES_W-1:0] nbytes;
    logic [CNT_W-1:0]   cnt;
    logic [PAGE_W-1:0]  pidx;
    int unsigned        first_pg;
    int unsigned        end_pg;
    int unsigned        need;
    int unsigned        sum;
    int unsigned        p;
    int unsigned        listed[$];
    stat_e              st;
    addr   = data[IN_ADDR_LSB +: ADDR_W];
    len    = data[IN_LEN_LSB +: LEN_W];
    nbytes = data[IN_BYTES_LSB +: BYTES_W];
    cnt    = data[IN_CNT_LSB +: CNT_W];
    pidx   = data[IN_PIDX_LSB +: PAGE_W];
    st     = STAT_OK;
    case (cmd)
      CMD_SCAN, CMD_PLACE: begin
        if (len == 0 || len > MAX_LENGTH) begin
          st = STAT_ERROR;
        end else begin
          first_pg = 32'(addr) >> PAGE_LOG2;
          end_pg   = (32'(addr) + 32'(len) - 1) >> PAGE_LOG2;
          if (end_pg >= NUM_PAGES || end_pg - first_pg + 1 > SPAN_LIMIT) begin
            st = STAT_ERROR;
          end else begin
            for (p = first_pg; p <= end_pg; p++) begin
              if (!resident[p]) begin
                if (cmd == CMD_SCAN) begin
                  listed.insert(listed.size(), p);
                end else if (place_left != 0) begin
                  resident[p] = 1'b1;
                  place_left--;
                  // free count saturates at zero
                  if (free_left != 0) free_left--;
                  listed.insert(listed.size(), p);
                end
              end
            end
          end
        end
      end
      CMD_ALLOC_BYTES: begin
        if (nbytes == 0) begin
          st = STAT_REFUSED;
        end else begin
          need = ((32'(nbytes) - 1) >> PAGE_LOG2) + 1;
          if (free_left >= need) free_left = free_left - CNT_W'(need);
          else st = STAT_REFUSED;
        end
      end
      CMD_ALLOC_CNT: begin
        if (free_left >= cnt) free_left = free_left - cnt;
        else st = STAT_ERROR;
      end
      CMD_FREE_CNT: begin
        sum = 32'(free_left) + 32'(cnt);
        if (sum <= total_pages) free_left = CNT_W'(sum);
        else st = STAT_ERROR;
      end
      CMD_VALIDATE: begin
        if (resident[pidx]) st = STAT_ERROR;
        else resident[pidx] = 1'b1;
      end
      CMD_INVALIDATE: begin
        if (!resident[pidx]) st = STAT_ERROR;
        else resident[pidx] = 1'b0;
      end
      default: begin
        free_left  = total_pages;
        place_left = total_pages;
      end
    endcase
    // counts on listed beats are the ones after the whole command
    foreach (listed[i]) push_beat(PAGE_W'(listed[i]), 1'b1, STAT_OK, 1'b0);
    push_beat('0, 1'b0, st, 1'b1);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("result field %s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  task automatic check_beat();
    result_beat_t e;
    if (expected_beats.size() == 0) begin
      $error("result beat with nothing expected: tdata %h tuser %b tlast %b",
             m_tdata, m_tuser, m_tlast);
      fail_count_o++;
    end else begin
      e = expected_beats.pop_front();
      compare_field("page_number", 32'(e.page_number), 32'(m_tdata[OUT_PAGE_LSB +: PAGE_W]));
      compare_field("page_listed", 32'(e.page_listed), 32'(m_tuser));
      compare_field("status", 32'(e.status), 32'(m_tdata[OUT_STAT_LSB +: STAT_W]));
      compare_field("free_count", 32'(e.free_count), 32'(m_tdata[OUT_FREE_LSB +: CNT_W]));
      compare_field("remain_count", 32'(e.remain_count), 32'(m_tdata[OUT_REM_LSB +: CNT_W]));
      compare_field("last", 32'(e.last), 32'(m_tlast));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resident    = '{default: 1'b0};
      total_pages = TOTAL_RESET;
      free_left   = TOTAL_RESET;
      place_left  = TOTAL_RESET;
      expected_beats.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat();
      // a new total is loaded on reset counters and bounds the free count
      if (cfg_valid_i && cfg_ready_o) total_pages = cfg_wdata_i;
      if (s_tvalid && s_tready) predict_command(cmd_e'(s_tuser), s_tdata);
    end
    pending_o = expected_beats.size();
  end

endmodule

>>> sim/tb_page_residency_manager.sv
`timescale 1ns / 1ps

module tb_page_residency_manager;
  import prm_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CNT_W-1:0]       cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;

  page_residency_manager u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_wdata_i(cfg_wdata_i)
  );

  prm_stream_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("tb_page_residency_manager: FAIL");
    $finish;
  end

  // leaves at a falling edge with tvalid still high so back-to-back beats stay gapless
  task automatic send_cmd(input cmd_e cmd, input logic [ADDR_W-1:0] addr,
                          input logic [LEN_W-1:0] len, input logic [BYTES_W-1:0] nbytes,
                          input logic [CNT_W-1:0] cnt, input logic [PAGE_W-1:0] pidx);
    logic [IN_TDATA_W-1:0] data;
    data = '0;
    data[IN_ADDR_LSB +: ADDR_W]   = addr;
    data[IN_LEN_LSB +: LEN_W]     = len;
    data[IN_BYTES_LSB +: BYTES_W] = nbytes;
    data[IN_CNT_LSB +: CNT_W]     = cnt;
    data[IN_PIDX_LSB +: PAGE_W]   = pidx;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_total(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly legal commands in a small page window so that pages get reused
  task automatic send_random();
    cmd_e               cmd;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [BYTES_W-1:0] nbytes;
    logic [CNT_W-1:0]   cnt;
    logic [PAGE_W-1:0]  pidx;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 45) cmd = $urandom_range(1) ? CMD_PLACE : CMD_SCAN;
    else cmd = cmd_e'($urandom_range(7));
    addr = ($urandom_range(3) == 0) ? ADDR_W'($urandom())
                                    : ADDR_W'($urandom_range(32 * 4096 - 1));
    pick = $urandom_range(99);
    if (pick < 8) len = LEN_W'($urandom());
    else if (pick < 60) len = LEN_W'($urandom_range(1, 16384));
    else len = LEN_W'($urandom_range(1, MAX_LENGTH));
    pick = $urandom_range(99);
    if (pick < 5) nbytes = '0;
    else if (pick < 30) nbytes = BYTES_W'($urandom());
    else nbytes = BYTES_W'($urandom_range(1, 65536));
    cnt  = ($urandom_range(3) == 0) ? CNT_W'($urandom()) : CNT_W'($urandom_range(64));
    pidx = ($urandom_range(3) == 0) ? PAGE_W'($urandom()) : PAGE_W'($urandom_range(31));
    send_cmd(cmd, addr, len, nbytes, cnt, pidx);
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    logic [CNT_W-1:0] phase_total[4];
    rst_ni <= 1'b0;
    phase_idle  = '{0, 58, 0, 15};
    phase_stall = '{0, 0, 58, 15};
    phase_total = '{CNT_W'(4096), CNT_W'(17), CNT_W'(4096), CNT_W'($urandom_range(4096))};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_total(CNT_W'(4096));
    send_cmd(CMD_SCAN, 24'h0, 17'd1, '0, '0, '0);
    send_cmd(CMD_PLACE, 24'h0, 17'd65536, '0, '0, '0);
    send_cmd(CMD_SCAN, 24'd4095, 17'd65536, '0, '0, '0);
    send_cmd(CMD_SCAN, 24'h0, 17'd0, '0, '0, '0);
    send_cmd(CMD_SCAN, 24'h0, 17'd65537, '0, '0, '0);
    send_cmd(CMD_PLACE, 24'hFFFFFF, 17'h1FFFF, '0, '0, '0);
    send_cmd(CMD_SCAN, 24'hFFF000, 17'd4096, '0, '0, '0);
    // range ending one page past the top of memory
    send_cmd(CMD_PLACE, 24'hFFF001, 17'd4096, '0, '0, '0);
    send_cmd(CMD_ALLOC_BYTES, '0, '0, 25'd0, '0, '0);
    send_cmd(CMD_ALLOC_BYTES, '0, '0, 25'd1, '0, '0);
    send_cmd(CMD_ALLOC_BYTES, '0, '0, 25'd4097, '0, '0);
    send_cmd(CMD_ALLOC_BYTES, '0, '0, 25'h1FFFFFF, '0, '0);
    send_cmd(CMD_ALLOC_CNT, '0, '0, '0, 13'd0, '0);
    send_cmd(CMD_ALLOC_CNT, '0, '0, '0, 13'h1FFF, '0);
    send_cmd(CMD_FREE_CNT, '0, '0, '0, 13'h1FFF, '0);
    send_cmd(CMD_FREE_CNT, '0, '0, '0, 13'd3, '0);
    send_cmd(CMD_VALIDATE, '0, '0, '0, '0, 12'hFFF);
    send_cmd(CMD_VALIDATE, '0, '0, '0, '0, 12'hFFF);
    send_cmd(CMD_INVALIDATE, '0, '0, '0, '0, 12'hFFF);
    send_cmd(CMD_INVALIDATE, '0, '0, '0, '0, 12'hFFF);
    send_cmd(CMD_INVALIDATE, '0, '0, '0, '0, 12'h0);
    send_cmd(CMD_RESET_CNT, '0, '0, '0, '0, '0);
    // placing with no free pages left keeps the free count at zero
    send_cmd(CMD_ALLOC_CNT, '0, '0, '0, 13'd4096, '0);
    send_cmd(CMD_PLACE, 24'h100000, 17'd8192, '0, '0, '0);
    // placements run out in the middle of a range
    write_total(CNT_W'(3));
    send_cmd(CMD_RESET_CNT, '0, '0, '0, '0, '0);
    send_cmd(CMD_PLACE, 24'h200000, 17'd65536, '0, '0, '0);
    send_cmd(CMD_PLACE, 24'h300000, 17'd8192, '0, '0, '0);
    write_total(CNT_W'(0));
    send_cmd(CMD_RESET_CNT, '0, '0, '0, '0, '0);
    send_cmd(CMD_FREE_CNT, '0, '0, '0, 13'd1, '0);

    for (int ph = 0; ph < 4; ph++) begin
      write_total(phase_total[ph]);
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      send_cmd(CMD_RESET_CNT, '0, '0, '0, '0, '0);
      repeat (20) send_random();
    end

    drain_results();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_page_residency_manager: PASS");
    end else begin
      $display("tb_page_residency_manager: FAIL");
    end
    $finish;
  end

endmodule
